// ----- sv/scc_pkg.sv -----
// Shared types and constants for the strongly connected component block.
// No dependencies; the engine, the top level and the checker import this package.
package scc_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 4096;
    localparam int NODE_W    = $clog2(MAX_NODES);      // node number
    localparam int CNT_W     = NODE_W + 1;             // node count, 0..MAX_NODES
    localparam int EADDR_W   = $clog2(MAX_EDGES);      // edge memory address
    localparam int ECNT_W    = EADDR_W + 1;            // edge count, 0..MAX_EDGES
    localparam int STK_W     = NODE_W + 2 * ECNT_W;    // node, cursor, list end

    // Request type codes.
    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_CNT_RD, S_CNT_CHK, S_CNT_WR, S_PFX_RD, S_PFX_WR,
        S_FIL_RD, S_FIL_CHK, S_FIL_WR, S_F_OUT, S_F_OUT2, S_D_ST1, S_D_ST2,
        S_D_LOOP, S_D_ADJ, S_D_VIS, S_D_BEST, S_D_POP, S_CLR2, S_R_OUT,
        S_R_OUT2, S_R_OUT3, S_DONE
    } t_state;

    // Commands from the front end to the engine.
    typedef struct packed {
        logic              load;
        logic              compute;
        logic              take;
        logic [CNT_W-1:0]  nodes;
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
    } t_cmd;

    // Status and result from the engine.
    typedef struct packed {
        logic             idle;
        logic             done;
        logic [CNT_W-1:0] longest;
        logic [CNT_W-1:0] total;
        logic             overflow;
    } t_res;

endpackage

// ----- sv/scc_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module scc_ram #(
    parameter int W = 8,
    parameter int D = 16,
    localparam int AW = $clog2(D)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] mem [D];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

// ----- sv/scc_engine.sv -----
// Graph engine: edge store, adjacency build, two depth-first passes and path weights.
// Depends on scc_pkg and scc_ram.
module scc_engine import scc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    output t_res o_res
);

    t_state r_state, n_state;

    logic [ECNT_W-1:0] r_idx, r_ecount, r_acc_f, r_acc_r, r_cur_pos, r_cur_end;
    logic [CNT_W-1:0]  r_n, r_depth, r_done, r_k, r_total, r_size, r_curbest, r_best;
    logic [NODE_W-1:0] r_a, r_b, r_v, r_c, r_cur_node;
    logic              r_ok, r_ovf, r_rev;

    // Memory ports.
    logic                es_we, fs_we, rs_we, fc_we, rc_we, fa_we, ra_we;
    logic                vi_we, st_we, fi_we, co_we, be_we;
    logic [EADDR_W-1:0]  es_wa, es_ra, fa_wa, ra_wa, ad_ra;
    logic [CNT_W-1:0]    fs_wa, rs_wa, fs_ra, rs_ra;
    logic [NODE_W-1:0]   fc_wa, rc_wa, fc_ra, rc_ra, vi_wa, vi_ra, st_wa, st_ra;
    logic [NODE_W-1:0]   fi_wa, fi_ra, co_wa, co_ra, be_wa, be_ra;
    logic [ECNT_W-1:0]   fs_wd, rs_wd, fc_wd, rc_wd, fs_q, rs_q, fc_q, rc_q;
    logic [NODE_W-1:0]   fa_wd, ra_wd, fa_q, ra_q, esrc_q, etgt_q, fi_q, co_q, co_wd;
    logic [CNT_W-1:0]    be_wd, be_q;
    logic [STK_W-1:0]    st_q;
    logic                vi_wd, vi_q;

    logic [CNT_W-1:0]  idx_n, nb;
    logic [ECNT_W-1:0] sd;
    logic [NODE_W-1:0] ad;
    logic              more, a_ok, b_ok;

    assign idx_n = r_idx[CNT_W-1:0];
    assign sd    = r_rev ? rs_q : fs_q;
    assign ad    = r_rev ? ra_q : fa_q;
    assign more  = (r_cur_pos < r_cur_end);
    assign nb    = r_curbest + r_size;
    assign a_ok  = ({1'b0, esrc_q} < r_n);
    assign b_ok  = ({1'b0, etgt_q} < r_n);

    scc_ram #(.W(NODE_W), .D(MAX_EDGES)) u_esrc (.i_clk, .i_we(es_we), .i_waddr(es_wa),
        .i_wdata(i_cmd.src), .i_raddr(es_ra), .o_rdata(esrc_q));
    scc_ram #(.W(NODE_W), .D(MAX_EDGES)) u_etgt (.i_clk, .i_we(es_we), .i_waddr(es_wa),
        .i_wdata(i_cmd.dst), .i_raddr(es_ra), .o_rdata(etgt_q));
    scc_ram #(.W(ECNT_W), .D(MAX_NODES + 1)) u_fstart (.i_clk, .i_we(fs_we),
        .i_waddr(fs_wa), .i_wdata(fs_wd), .i_raddr(fs_ra), .o_rdata(fs_q));
    scc_ram #(.W(ECNT_W), .D(MAX_NODES + 1)) u_rstart (.i_clk, .i_we(rs_we),
        .i_waddr(rs_wa), .i_wdata(rs_wd), .i_raddr(rs_ra), .o_rdata(rs_q));
    scc_ram #(.W(ECNT_W), .D(MAX_NODES)) u_fcur (.i_clk, .i_we(fc_we), .i_waddr(fc_wa),
        .i_wdata(fc_wd), .i_raddr(fc_ra), .o_rdata(fc_q));
    scc_ram #(.W(ECNT_W), .D(MAX_NODES)) u_rcur (.i_clk, .i_we(rc_we), .i_waddr(rc_wa),
        .i_wdata(rc_wd), .i_raddr(rc_ra), .o_rdata(rc_q));
    scc_ram #(.W(NODE_W), .D(MAX_EDGES)) u_fadj (.i_clk, .i_we(fa_we), .i_waddr(fa_wa),
        .i_wdata(fa_wd), .i_raddr(ad_ra), .o_rdata(fa_q));
    scc_ram #(.W(NODE_W), .D(MAX_EDGES)) u_radj (.i_clk, .i_we(ra_we), .i_waddr(ra_wa),
        .i_wdata(ra_wd), .i_raddr(ad_ra), .o_rdata(ra_q));
    scc_ram #(.W(1), .D(MAX_NODES)) u_vis (.i_clk, .i_we(vi_we), .i_waddr(vi_wa),
        .i_wdata(vi_wd), .i_raddr(vi_ra), .o_rdata(vi_q));
    scc_ram #(.W(STK_W), .D(MAX_NODES)) u_stack (.i_clk, .i_we(st_we), .i_waddr(st_wa),
        .i_wdata({r_cur_node, r_cur_pos, r_cur_end}), .i_raddr(st_ra), .o_rdata(st_q));
    scc_ram #(.W(NODE_W), .D(MAX_NODES)) u_finish (.i_clk, .i_we(fi_we), .i_waddr(fi_wa),
        .i_wdata(r_cur_node), .i_raddr(fi_ra), .o_rdata(fi_q));
    scc_ram #(.W(NODE_W), .D(MAX_NODES)) u_comp (.i_clk, .i_we(co_we), .i_waddr(co_wa),
        .i_wdata(co_wd), .i_raddr(co_ra), .o_rdata(co_q));
    scc_ram #(.W(CNT_W), .D(MAX_NODES)) u_best (.i_clk, .i_we(be_we), .i_waddr(be_wa),
        .i_wdata(be_wd), .i_raddr(be_ra), .o_rdata(be_q));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_cmd.compute) n_state = S_CLR;
            S_CLR:     if (idx_n == r_n) n_state = S_CNT_RD;
            S_CNT_RD:  n_state = (r_idx == r_ecount) ? S_PFX_RD : S_CNT_CHK;
            S_CNT_CHK: n_state = S_CNT_WR;
            S_CNT_WR:  n_state = S_CNT_RD;
            S_PFX_RD:  n_state = (idx_n == r_n) ? S_FIL_RD : S_PFX_WR;
            S_PFX_WR:  n_state = S_PFX_RD;
            S_FIL_RD:  n_state = (r_idx == r_ecount) ? S_F_OUT : S_FIL_CHK;
            S_FIL_CHK: n_state = S_FIL_WR;
            S_FIL_WR:  n_state = S_FIL_RD;
            S_F_OUT:   n_state = (idx_n == r_n) ? S_CLR2 : S_F_OUT2;
            S_F_OUT2:  n_state = vi_q ? S_F_OUT : S_D_ST1;
            S_D_ST1:   n_state = S_D_ST2;
            S_D_ST2:   n_state = S_D_LOOP;
            S_D_LOOP: begin
                if (more) n_state = S_D_ADJ;
                else if (r_depth == CNT_W'(1)) n_state = r_rev ? S_R_OUT : S_F_OUT;
                else n_state = S_D_POP;
            end
            S_D_ADJ:   n_state = S_D_VIS;
            S_D_VIS:   n_state = !vi_q ? S_D_ST1 : (r_rev ? S_D_BEST : S_D_LOOP);
            S_D_BEST:  n_state = S_D_LOOP;
            S_D_POP:   n_state = S_D_LOOP;
            S_CLR2:    if (idx_n == r_n) n_state = S_R_OUT;
            S_R_OUT:   n_state = (r_k == '0) ? S_DONE : S_R_OUT2;
            S_R_OUT2:  n_state = S_R_OUT3;
            S_R_OUT3:  n_state = vi_q ? S_R_OUT : S_D_ST1;
            S_DONE:    if (i_cmd.take) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Memory addresses, data and write enables for each state.
    always_comb begin
        es_we = 1'b0; fs_we = 1'b0; rs_we = 1'b0; fc_we = 1'b0; rc_we = 1'b0;
        fa_we = 1'b0; ra_we = 1'b0; vi_we = 1'b0; st_we = 1'b0; fi_we = 1'b0;
        co_we = 1'b0; be_we = 1'b0;
        es_wa = r_ecount[EADDR_W-1:0];
        es_ra = r_idx[EADDR_W-1:0];
        fs_wa = idx_n; rs_wa = idx_n; fs_wd = '0; rs_wd = '0;
        fs_ra = idx_n + CNT_W'(1); rs_ra = idx_n + CNT_W'(1);
        fc_wa = r_a; rc_wa = r_b; fc_wd = r_acc_f; rc_wd = r_acc_r;
        fc_ra = esrc_q; rc_ra = etgt_q;
        fa_wa = fc_q[EADDR_W-1:0]; ra_wa = rc_q[EADDR_W-1:0];
        fa_wd = r_b; ra_wd = r_a;
        ad_ra = r_cur_pos[EADDR_W-1:0];
        vi_wa = r_idx[NODE_W-1:0]; vi_wd = 1'b0; vi_ra = r_idx[NODE_W-1:0];
        st_wa = NODE_W'(r_depth - CNT_W'(1));
        st_ra = NODE_W'(r_depth - CNT_W'(2));
        fi_wa = r_done[NODE_W-1:0]; fi_ra = NODE_W'(r_k - CNT_W'(1));
        co_wa = r_v; co_wd = r_total[NODE_W-1:0]; co_ra = ad;
        be_wa = r_total[NODE_W-1:0]; be_wd = nb; be_ra = co_q;
        unique case (r_state)
            S_IDLE: es_we = i_cmd.load && (r_ecount < ECNT_W'(MAX_EDGES));
            S_CLR: begin
                fs_we = 1'b1;
                rs_we = 1'b1;
                vi_we = (idx_n < r_n);
            end
            S_CNT_CHK: begin
                fs_ra = {1'b0, esrc_q} + CNT_W'(1);
                rs_ra = {1'b0, etgt_q} + CNT_W'(1);
            end
            S_CNT_WR: begin
                fs_we = r_ok; fs_wa = {1'b0, r_a} + CNT_W'(1); fs_wd = fs_q + ECNT_W'(1);
                rs_we = r_ok; rs_wa = {1'b0, r_b} + CNT_W'(1); rs_wd = rs_q + ECNT_W'(1);
            end
            S_PFX_WR: begin
                fs_we = 1'b1; fs_wa = idx_n + CNT_W'(1); fs_wd = r_acc_f + fs_q;
                rs_we = 1'b1; rs_wa = idx_n + CNT_W'(1); rs_wd = r_acc_r + rs_q;
                fc_we = 1'b1; fc_wa = r_idx[NODE_W-1:0];
                rc_we = 1'b1; rc_wa = r_idx[NODE_W-1:0];
            end
            S_FIL_WR: begin
                fa_we = r_ok; ra_we = r_ok;
                fc_we = r_ok; fc_wd = fc_q + ECNT_W'(1);
                rc_we = r_ok; rc_wd = rc_q + ECNT_W'(1);
            end
            S_F_OUT2: begin
                vi_we = !vi_q; vi_wd = 1'b1;
                fs_ra = idx_n; rs_ra = idx_n;
            end
            S_D_ST1: begin
                fs_ra = {1'b0, r_cur_node} + CNT_W'(1);
                rs_ra = {1'b0, r_cur_node} + CNT_W'(1);
            end
            S_D_LOOP: begin
                fi_we = !more && !r_rev;
                be_we = !more && r_rev && (r_depth == CNT_W'(1));
            end
            S_D_ADJ: vi_ra = ad;
            S_D_VIS: begin
                vi_we = !vi_q; vi_wa = r_v; vi_wd = 1'b1;
                st_we = !vi_q;
                co_we = !vi_q && r_rev;
                fs_ra = {1'b0, r_v}; rs_ra = {1'b0, r_v};
            end
            S_CLR2: vi_we = (idx_n < r_n);
            S_R_OUT2: vi_ra = fi_q;
            S_R_OUT3: begin
                vi_we = !vi_q; vi_wa = r_cur_node; vi_wd = 1'b1;
                co_we = !vi_q; co_wa = r_cur_node;
                fs_ra = {1'b0, r_cur_node}; rs_ra = {1'b0, r_cur_node};
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ecount <= '0;
            r_ovf    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_cmd.load) begin
                if (r_ecount < ECNT_W'(MAX_EDGES)) r_ecount <= r_ecount + ECNT_W'(1);
                else r_ovf <= 1'b1;
            end
            if (r_state == S_DONE && i_cmd.take) begin
                r_ecount <= '0;
                r_ovf    <= 1'b0;
            end
        end
    end

    // Walk registers: counters, cursors and the top of the depth-first stack.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_n   <= i_cmd.nodes;
                r_idx <= '0;
            end
            S_CLR: r_idx <= (idx_n == r_n) ? '0 : r_idx + ECNT_W'(1);
            S_CNT_RD: begin
                if (r_idx == r_ecount) r_idx <= '0;
                r_acc_f <= '0;
                r_acc_r <= '0;
            end
            S_CNT_CHK, S_FIL_CHK: begin
                r_a  <= esrc_q;
                r_b  <= etgt_q;
                r_ok <= a_ok && b_ok;
            end
            S_CNT_WR, S_FIL_WR: r_idx <= r_idx + ECNT_W'(1);
            S_PFX_RD: if (idx_n == r_n) r_idx <= '0;
            S_PFX_WR: begin
                r_acc_f <= r_acc_f + fs_q;
                r_acc_r <= r_acc_r + rs_q;
                r_idx   <= r_idx + ECNT_W'(1);
            end
            S_FIL_RD: begin
                if (r_idx == r_ecount) r_idx <= '0;
                r_rev  <= 1'b0;
                r_done <= '0;
            end
            S_F_OUT: if (idx_n == r_n) r_idx <= '0;
            S_F_OUT2: begin
                if (vi_q) r_idx <= r_idx + ECNT_W'(1);
                r_cur_node <= r_idx[NODE_W-1:0];
                r_depth    <= '0;
            end
            S_D_ST1: r_cur_pos <= sd;
            S_D_ST2: begin
                r_cur_end <= sd;
                r_depth   <= r_depth + CNT_W'(1);
            end
            S_D_LOOP: begin
                if (more) begin
                    r_cur_pos <= r_cur_pos + ECNT_W'(1);
                end else begin
                    if (!r_rev) r_done <= r_done + CNT_W'(1);
                    r_depth <= r_depth - CNT_W'(1);
                    if (r_depth == CNT_W'(1)) begin
                        if (r_rev) begin
                            r_total <= r_total + CNT_W'(1);
                            if (nb > r_best) r_best <= nb;
                        end else begin
                            r_idx <= r_idx + ECNT_W'(1);
                        end
                    end
                end
            end
            S_D_ADJ: r_v <= ad;
            S_D_VIS: begin
                if (!vi_q) begin
                    r_cur_node <= r_v;
                    if (r_rev) r_size <= r_size + CNT_W'(1);
                end
                r_c <= co_q;
            end
            S_D_BEST: begin
                // A neighbor inside the component being labeled adds nothing.
                if (({1'b0, r_c} != r_total) && (be_q > r_curbest)) r_curbest <= be_q;
            end
            S_D_POP: {r_cur_node, r_cur_pos, r_cur_end} <= st_q;
            S_CLR2: begin
                if (idx_n == r_n) begin
                    r_rev   <= 1'b1;
                    r_k     <= r_done;
                    r_total <= '0;
                    r_best  <= '0;
                end else begin
                    r_idx <= r_idx + ECNT_W'(1);
                end
            end
            S_R_OUT2: r_cur_node <= fi_q;
            S_R_OUT3: begin
                r_k       <= r_k - CNT_W'(1);
                r_size    <= CNT_W'(1);
                r_curbest <= '0;
                r_depth   <= '0;
            end
            default: ;
        endcase
    end

    // Status to the front end.
    always_comb begin
        o_res.idle     = (r_state == S_IDLE);
        o_res.done     = (r_state == S_DONE);
        o_res.longest  = r_best;
        o_res.total    = r_total;
        o_res.overflow = r_ovf;
    end

endmodule

// ----- sv/scc_condensed_longest_path.sv -----
// Top level: request handshake, node count register, edge range filter and result register.
// Depends on scc_pkg and scc_engine.
//
//   channel   direction  handshake            payload
//   request   in         i_valid / o_ready    i_req_type, i_edge_from, i_edge_to
//   result    out        o_valid / i_ready    o_longest_weight, o_component_total,
//                                             o_edge_overflow
//   config    in         i_cfg_we             i_cfg_data (node count)
//
// Edges can follow back to back.
// A compute request is worked through by a walk over the edge, list and stack memories.
// No request is taken until the result has moved into the output register.
// Reset is synchronous and active low; no memory clearing pass is needed.
// A stalled result holds in the output register while edge requests are still taken.
module scc_condensed_longest_path import scc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_req_type,
    input  logic [CNT_W-1:0]  i_edge_from,
    input  logic [CNT_W-1:0]  i_edge_to,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CNT_W-1:0]  o_longest_weight,
    output logic [CNT_W-1:0]  o_component_total,
    output logic              o_edge_overflow,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_data
);

    logic [CNT_W-1:0] r_node_count, eff_n;
    logic             r_ovalid, accept, in_range;
    t_cmd             cmd;
    t_res             res;

    // Node count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_node_count <= CNT_W'(1);
        else if (i_cfg_we) r_node_count <= i_cfg_data;
    end

    assign eff_n = (r_node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : r_node_count;

    // Edges with an endpoint outside 1..N are dropped here.
    assign in_range = (i_edge_from != '0) && (i_edge_from <= eff_n) &&
                      (i_edge_to != '0) && (i_edge_to <= eff_n);

    assign o_ready = res.idle;
    assign accept  = i_valid && o_ready;

    always_comb begin
        cmd.load    = accept && (i_req_type == REQ_LOAD) && in_range;
        cmd.compute = accept && (i_req_type == REQ_COMPUTE);
        cmd.take    = !r_ovalid || i_ready;
        cmd.nodes   = eff_n;
        cmd.src     = NODE_W'(i_edge_from - CNT_W'(1));
        cmd.dst     = NODE_W'(i_edge_to - CNT_W'(1));
    end

    scc_engine u_engine (
        .i_clk,
        .i_rst_n,
        .i_cmd (cmd),
        .o_res (res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res.done && cmd.take) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.done && cmd.take) begin
            o_longest_weight  <= res.longest;
            o_component_total <= res.total;
            o_edge_overflow   <= res.overflow;
        end
    end

    assign o_valid = r_ovalid;

endmodule

// ----- sv/scc_checker.sv -----
// Port-level checks for the top level, attached by a bind statement.
// Depends on scc_pkg.
module scc_checker import scc_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              i_req_type,
    input logic              o_valid,
    input logic              i_ready,
    input logic [CNT_W-1:0]  o_longest_weight,
    input logic [CNT_W-1:0]  o_component_total,
    input logic              o_edge_overflow
);

    // A stalled result stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_longest_weight) && $stable(o_component_total)
            && $stable(o_edge_overflow))
        else $error("result changed while stalled");

    // A compute request blocks further requests while the graph is walked.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_req_type == REQ_COMPUTE) |=> !o_ready)
        else $error("request taken during compute");

    // No components means no path weight, and the other way round.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_component_total == '0) == (o_longest_weight == '0)))
        else $error("weight and component count disagree");

endmodule

bind scc_condensed_longest_path scc_checker u_scc_checker (.*);
